### design/bsc_pkg.sv
package bsc_pkg;

    localparam int NUM_PROCS  = 8;
    localparam int NUM_RES    = 3;
    localparam int CNT_W      = 8;
    localparam int WORK_W     = 12;
    localparam int IDX_W      = 3;
    localparam int PROC_W     = $clog2(NUM_PROCS);
    localparam int ROWS_W     = $clog2(NUM_PROCS + 1);
    localparam int ROW_W      = 2 * NUM_RES * CNT_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = CNT_W;

    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [WORK_W-1:0]     work_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_AVAIL_0 = cfg_addr_t'(0);
    localparam cfg_addr_t REG_AVAIL_1 = cfg_addr_t'(1);
    localparam cfg_addr_t REG_AVAIL_2 = cfg_addr_t'(2);

    // Port bundle for the process row memory: max claims in the low half,
    // allocations in the high half.
    typedef struct packed {
        logic              we;
        logic [PROC_W-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic [PROC_W-1:0] raddr;
    } row_req_t;

    // Port bundle for the safe sequence memory.
    typedef struct packed {
        logic              we;
        logic [PROC_W-1:0] waddr;
        logic [PROC_W-1:0] wdata;
        logic [PROC_W-1:0] raddr;
    } seq_req_t;

    // Work count plus a held allocation, saturating at the top of the range.
    function automatic work_t work_add(work_t w, cnt_t a);
        logic [WORK_W:0] s;
        s = {1'b0, w} + {{(WORK_W - CNT_W + 1){1'b0}}, a};
        return s[WORK_W] ? {WORK_W{1'b1}} : s[WORK_W-1:0];
    endfunction

endpackage

### design/bsc_ram.sv
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/bsc_ctrl.sv
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ROW_W-1:0]               s_row,
    input  logic                           s_tlast,
    input  logic [NUM_RES-1:0][CNT_W-1:0]  avail,
    output row_req_t                       row_req,
    input  logic [ROW_W-1:0]               row_rdata,
    output seq_req_t                       seq_req,
    input  logic [PROC_W-1:0]              seq_rdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_safe,
    output logic [IDX_W-1:0]               m_idx,
    output logic                           m_last
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_EVAL,
        ST_SRD,
        ST_SCAP,
        ST_SHOW
    } state_t;

    state_t                          state_reg;
    logic [ROWS_W-1:0]               rows_reg;
    logic [PROC_W-1:0]               p_reg;
    logic [PROC_W-1:0]               k_reg;
    logic [ROWS_W-1:0]               fin_cnt_reg;
    logic [NUM_PROCS-1:0]            fin_flags_reg;
    logic                            found_reg;
    logic [NUM_RES-1:0][WORK_W-1:0]  work_reg;
    logic                            m_valid_reg;
    logic                            m_safe_reg;
    logic [IDX_W-1:0]                m_idx_reg;
    logic                            m_last_reg;

    logic                            s_accept;
    logic                            row_room;
    logic                            fits;
    logic                            take;
    logic                            pass_end;
    logic                            seq_last;
    logic [ROWS_W-1:0]               fin_cnt_next;
    logic                            found_next;
    logic [NUM_RES-1:0][WORK_W-1:0]  work_next;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign row_room = (rows_reg != ROWS_W'(NUM_PROCS));

    // The need is floored at zero when a process holds more than it claims.
    always_comb begin
        cnt_t mx;
        cnt_t al;
        cnt_t need;
        fits = 1'b1;
        for (int r = 0; r < NUM_RES; r++) begin
            mx   = row_rdata[r*CNT_W +: CNT_W];
            al   = row_rdata[(NUM_RES + r)*CNT_W +: CNT_W];
            need = (mx > al) ? mx - al : '0;
            if (work_t'(need) > work_reg[r]) begin
                fits = 1'b0;
            end
            work_next[r] = work_add(work_reg[r], al);
        end
    end

    assign take         = !fin_flags_reg[p_reg] && fits;
    assign pass_end     = (ROWS_W'(p_reg) + ROWS_W'(1)) == rows_reg;
    assign seq_last     = (ROWS_W'(k_reg) + ROWS_W'(1)) == rows_reg;
    assign fin_cnt_next = fin_cnt_reg + ROWS_W'(take);
    assign found_next   = found_reg || take;

    always_comb begin
        row_req.we    = s_accept && row_room;
        row_req.waddr = rows_reg[PROC_W-1:0];
        row_req.wdata = s_row;
        row_req.raddr = p_reg;
        seq_req.we    = (state_reg == ST_EVAL) && take;
        seq_req.waddr = fin_cnt_reg[PROC_W-1:0];
        seq_req.wdata = p_reg;
        seq_req.raddr = k_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            rows_reg      <= '0;
            fin_cnt_reg   <= '0;
            fin_flags_reg <= '0;
            found_reg     <= 1'b0;
            p_reg         <= '0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (row_room) begin
                            rows_reg <= rows_reg + ROWS_W'(1);
                        end
                        if (s_tlast) begin
                            for (int r = 0; r < NUM_RES; r++) begin
                                work_reg[r] <= WORK_W'(avail[r]);
                            end
                            fin_flags_reg <= '0;
                            fin_cnt_reg   <= '0;
                            found_reg     <= 1'b0;
                            p_reg         <= '0;
                            state_reg     <= ST_RD;
                        end
                    end
                end
                // The row memory address is held through the read state and the evaluation
                // state, so the read data in the evaluation cycle belongs to the current process.
                ST_RD: begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (take) begin
                        work_reg             <= work_next;
                        fin_flags_reg[p_reg] <= 1'b1;
                    end
                    fin_cnt_reg <= fin_cnt_next;
                    if (pass_end) begin
                        if (fin_cnt_next == rows_reg) begin
                            k_reg     <= '0;
                            state_reg <= ST_SRD;
                        end else if (!found_next) begin
                            m_safe_reg  <= 1'b0;
                            m_idx_reg   <= '0;
                            m_last_reg  <= 1'b1;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_SHOW;
                        end else begin
                            p_reg     <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        found_reg <= found_next;
                        p_reg     <= p_reg + PROC_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_SRD: begin
                    state_reg <= ST_SCAP;
                end
                ST_SCAP: begin
                    m_safe_reg  <= 1'b1;
                    m_idx_reg   <= IDX_W'(seq_rdata);
                    m_last_reg  <= seq_last;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            rows_reg      <= '0;
                            fin_cnt_reg   <= '0;
                            fin_flags_reg <= '0;
                            state_reg     <= ST_LOAD;
                        end else begin
                            k_reg     <= k_reg + PROC_W'(1);
                            state_reg <= ST_SRD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_safe  = m_safe_reg;
    assign m_idx   = m_idx_reg;
    assign m_last  = m_last_reg;

endmodule

### design/bankers_safety_check.sv
// Banker's safety check. Process rows (maximum claim and current allocation
// for three resource types) are taken one per cycle on the slave side; the
// row marked with tlast starts the check, and rows beyond the eighth are
// dropped. The check over a batch of n rows walks the row memory in index
// order, pass after pass, going through a read state and an evaluation
// state for each process it visits because of the registered memory read.
// A safe outcome then gives n requests on the master side, one per process
// in sequence order with tuser high and tlast on the final one; each is
// fetched from the sequence memory through a read state and a capture state
// once the check ends or the request before it is accepted. An unsafe
// outcome gives a single request with tuser low, index zero and tlast high
// in the cycle after the check ends. No row is taken from the end of loading
// until the final result has been accepted. The available counts are written
// on the configuration port by the user only while the block is idle, which
// the block does not enforce, and they persist across batches.
module bankers_safety_check
    import bsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // max_0, max_1, max_2, alloc_0, alloc_1, alloc_2
    input  logic [ROW_W-1:0]      s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // process_index, zero padded
    output logic [7:0]            m_tdata,
    // safe
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic [NUM_RES-1:0][CNT_W-1:0] avail_reg;
    row_req_t                      row_req;
    seq_req_t                      seq_req;
    logic [ROW_W-1:0]              row_rdata;
    logic [PROC_W-1:0]             seq_rdata;
    logic [IDX_W-1:0]              m_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avail_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_AVAIL_0: avail_reg[0] <= cfg_wdata;
                REG_AVAIL_1: avail_reg[1] <= cfg_wdata;
                REG_AVAIL_2: avail_reg[2] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bsc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PROCS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_req.we),
        .waddr (row_req.waddr),
        .wdata (row_req.wdata),
        .raddr (row_req.raddr),
        .rdata (row_rdata)
    );

    bsc_ram #(
        .WIDTH (PROC_W),
        .DEPTH (NUM_PROCS)
    ) u_seq_ram (
        .aclk  (aclk),
        .we    (seq_req.we),
        .waddr (seq_req.waddr),
        .wdata (seq_req.wdata),
        .raddr (seq_req.raddr),
        .rdata (seq_rdata)
    );

    bsc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_row     (s_tdata),
        .s_tlast   (s_tlast),
        .avail     (avail_reg),
        .row_req   (row_req),
        .row_rdata (row_rdata),
        .seq_req   (seq_req),
        .seq_rdata (seq_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_safe    (m_tuser),
        .m_idx     (m_idx),
        .m_last    (m_tlast)
    );

    assign m_tdata = {{(8 - IDX_W){1'b0}}, m_idx};

endmodule
